// ===== rtl/core/pac_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pac_pkg
// Shared constants, codes and types of the pre-trigger audio capture core.
// ----------------------------------------------------------------------------
package pac_pkg;

	// ring geometry (DEPTH must be a power of two)
	localparam int unsigned DEPTH    = 524288;
	localparam int unsigned MAX_SPAN = 4096;
	localparam int unsigned ADDR_W   = $clog2(DEPTH);
	localparam int unsigned LEN_W    = ADDR_W + 1;

	localparam logic [LEN_W-1:0] STORE_LIMIT =
		(DEPTH > MAX_SPAN) ? LEN_W'(DEPTH - MAX_SPAN) : '0;
	localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(DEPTH);

	// field widths
	localparam int unsigned CMD_W      = 3;
	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned RATE_W     = 18;
	localparam int unsigned PAD_W      = 11;
	localparam int unsigned MAXD_W     = 16;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 18;

	// multiply-divide unit widths
	localparam int unsigned MD_A_W   = 32;
	localparam int unsigned MD_B_W   = 18;
	localparam int unsigned MD_P_W   = MD_A_W + MD_B_W;
	localparam int unsigned MD_CNT_W = $clog2(MD_P_W + 1);

	localparam logic [MD_B_W-1:0] MS_PER_S = MD_B_W'(1000);

	// commands
	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
	localparam logic [CMD_W-1:0] CMD_START  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_END    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ABORT  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_SLICE    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NO_SLICE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ     = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RATE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRE_PAD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POST_PAD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DUR  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE,
		ST_CAP,
		ST_DROP,
		ST_TRIM,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              go;
		logic [MD_A_W-1:0] a;
		logic [MD_B_W-1:0] b;
		logic [MD_B_W-1:0] d;
	} md_req_t;

	typedef struct packed {
		logic              done;
		logic [MD_P_W-1:0] q;
	} md_rsp_t;

	typedef struct packed {
		logic                we;
		logic [ADDR_W-1:0]   waddr;
		logic [SAMPLE_W-1:0] wdata;
		logic                re;
		logic [ADDR_W-1:0]   raddr;
	} ring_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/pac_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pac_ifs
// Channel interfaces: command input, result output, register write.
// ----------------------------------------------------------------------------
interface pac_req_if;
	logic                               valid;
	logic                               ready;
	logic [pac_pkg::CMD_W-1:0]          command;
	logic signed [pac_pkg::SAMPLE_W-1:0] sample;
	logic                               chunk_end;
	logic [pac_pkg::TIME_W-1:0]         time_ms;
	logic [pac_pkg::ADDR_W-1:0]         read_address;
	modport source (output valid, command, sample, chunk_end, time_ms, read_address,
		input ready);
	modport sink (input valid, command, sample, chunk_end, time_ms, read_address,
		output ready);
endinterface

interface pac_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [pac_pkg::KIND_W-1:0]         result_kind;
	logic [pac_pkg::ADDR_W-1:0]         slice_base;
	logic [pac_pkg::LEN_W-1:0]          slice_length;
	logic [pac_pkg::TIME_W-1:0]         slice_start_ms;
	logic [pac_pkg::TIME_W-1:0]         slice_end_ms;
	logic signed [pac_pkg::SAMPLE_W-1:0] read_sample;
	modport source (output valid, result_kind, slice_base, slice_length, slice_start_ms,
		slice_end_ms, read_sample, input ready);
	modport sink (input valid, result_kind, slice_base, slice_length, slice_start_ms,
		slice_end_ms, read_sample, output ready);
endinterface

interface pac_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [pac_pkg::CFG_IDX_W-1:0]    index;
	logic [pac_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pac_muldiv.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pac_muldiv
// Shared unit: registered a*b, then restoring division by d, one quotient
// bit per cycle. done pulses for one cycle with the quotient on q.
// ----------------------------------------------------------------------------
module pac_muldiv (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pac_pkg::md_req_t req,
	output pac_pkg::md_rsp_t      rsp
);

	logic                            busy_q;
	logic                            done_q;
	logic [pac_pkg::MD_CNT_W-1:0]    cnt_q;
	logic [pac_pkg::MD_P_W-1:0]      n_q;
	logic [pac_pkg::MD_B_W:0]        r_q;
	logic [pac_pkg::MD_B_W-1:0]      d_q;
	logic [pac_pkg::MD_B_W:0]        r_shift;
	logic                            fits;

	// trial subtract for the current quotient bit
	assign r_shift = {r_q[pac_pkg::MD_B_W-1:0], n_q[pac_pkg::MD_P_W-1]};
	assign fits    = r_shift >= {1'b0, d_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= pac_pkg::MD_CNT_W'(pac_pkg::MD_P_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == pac_pkg::MD_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// load the product, then shift quotient bits in
	always_ff @(posedge clk) begin
		if (req.go) begin
			n_q <= pac_pkg::MD_P_W'(req.a) * pac_pkg::MD_P_W'(req.b);
			d_q <= req.d;
			r_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[pac_pkg::MD_P_W-2:0], fits};
			r_q <= fits ? (r_shift - {1'b0, d_q}) : r_shift;
		end
	end

	assign rsp.done = done_q;
	assign rsp.q    = n_q;

endmodule
`default_nettype wire

// ===== rtl/core/pac_ring.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pac_ring
// Sample ring memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pac_ring (
	input  wire logic                          clk,
	input  wire pac_pkg::ring_req_t            req,
	output logic [pac_pkg::SAMPLE_W-1:0]       rdata
);

	logic [pac_pkg::SAMPLE_W-1:0] mem [pac_pkg::DEPTH];

	// write
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/pretrigger_audio_capture_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pretrigger_audio_capture_core
// Sample ring with rolling pre-trigger buffer, duration cap and tail trim.
// ----------------------------------------------------------------------------
// One item at a time. Every millisecond/sample conversion runs through one
// shared multiply then bit-serial divide unit. An idle append computes the
// pre-buffer capacity, and a recording append closing a chunk computes the
// cap, then a head drop also advances the start time. A speech end with a
// tail trim computes the trim length. A speech end or read waits while the
// output register still holds a result that has not been taken. No clearing
// pass: the ring is undefined until written.
module pretrigger_audio_capture_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	pac_req_if.sink     req,
	pac_rsp_if.source   rsp,
	pac_cfg_if.sink     cfg
);

	localparam int unsigned AW = pac_pkg::ADDR_W;
	localparam int unsigned LW = pac_pkg::LEN_W;
	localparam int unsigned TW = pac_pkg::TIME_W;
	localparam int unsigned PW = pac_pkg::MD_P_W;

	pac_pkg::state_t   state_q, state_d;
	pac_pkg::md_req_t  md_req;
	pac_pkg::md_rsp_t  md_rsp;
	pac_pkg::ring_req_t ring_req;
	logic [pac_pkg::SAMPLE_W-1:0] ring_rdata;

	// configuration
	logic [pac_pkg::RATE_W-1:0] rate_q;
	logic [pac_pkg::PAD_W-1:0]  pre_pad_q;
	logic [pac_pkg::PAD_W-1:0]  post_pad_q;
	logic [pac_pkg::MAXD_W-1:0] max_dur_q;

	// capture state
	logic [AW-1:0] wp_q;
	logic          rec_q;
	logic [LW-1:0] pre_q;
	logic [AW-1:0] base_q;
	logic [LW-1:0] len_q;
	logic [TW-1:0] start_q;

	// pending result
	logic [pac_pkg::KIND_W-1:0]   res_kind_q;
	logic [AW-1:0]                res_base_q;
	logic [LW-1:0]                res_len_q;
	logic [TW-1:0]                res_start_q;
	logic [TW-1:0]                res_end_q;
	logic [pac_pkg::SAMPLE_W-1:0] res_sample_q;

	// output register
	logic                         out_valid_q;
	logic [pac_pkg::KIND_W-1:0]   out_kind_q;
	logic [AW-1:0]                out_base_q;
	logic [LW-1:0]                out_len_q;
	logic [TW-1:0]                out_start_q;
	logic [TW-1:0]                out_end_q;
	logic [pac_pkg::SAMPLE_W-1:0] out_sample_q;

	logic          fire;
	logic          is_append, is_start, is_end, is_abort, is_read;
	logic [TW-1:0] diff;
	logic [TW:0]   dur;
	logic          dur_pos;
	logic [LW-1:0] q_sat;
	logic [LW-1:0] cap;
	logic          over;
	logic [LW-1:0] drop;
	logic          rate_nz;
	logic          out_free;
	logic [LW-1:0] pre_inc;

	assign fire      = req.valid && req.ready;
	assign is_append = req.command == pac_pkg::CMD_APPEND;
	assign is_start  = req.command == pac_pkg::CMD_START;
	assign is_end    = req.command == pac_pkg::CMD_END;
	assign is_abort  = req.command == pac_pkg::CMD_ABORT;
	assign is_read   = req.command == pac_pkg::CMD_READ;
	assign rate_nz   = rate_q != '0;
	assign out_free  = !out_valid_q || rsp.ready;

	// signed elapsed time plus post pad
	assign diff    = req.time_ms - start_q;
	assign dur     = {diff[TW-1], diff} + (TW+1)'(post_pad_q);
	assign dur_pos = !dur[TW] && (dur != '0);

	// saturate the unit's quotient to the storage limit
	assign q_sat = (md_rsp.q > PW'(pac_pkg::STORE_LIMIT)) ? pac_pkg::STORE_LIMIT
		: md_rsp.q[LW-1:0];
	assign cap   = (md_rsp.q == '0) ? pac_pkg::STORE_LIMIT : q_sat;
	assign over  = len_q > cap;
	assign drop  = len_q - cap;
	assign pre_inc = pre_q + 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pac_pkg::ST_IDLE: begin
				if (fire) begin
					if (is_append && !rec_q) begin
						state_d = pac_pkg::ST_PRE;
					end else if (is_append && req.chunk_end) begin
						state_d = pac_pkg::ST_CAP;
					end else if (is_end && rec_q && dur_pos) begin
						state_d = pac_pkg::ST_TRIM;
					end else if (is_end) begin
						state_d = pac_pkg::ST_EMIT;
					end else if (is_read) begin
						state_d = pac_pkg::ST_READ;
					end
				end
			end
			pac_pkg::ST_PRE: begin
				if (md_rsp.done) state_d = pac_pkg::ST_IDLE;
			end
			pac_pkg::ST_CAP: begin
				if (md_rsp.done) begin
					state_d = (over && rate_nz) ? pac_pkg::ST_DROP : pac_pkg::ST_IDLE;
				end
			end
			pac_pkg::ST_DROP: begin
				if (md_rsp.done) state_d = pac_pkg::ST_IDLE;
			end
			pac_pkg::ST_TRIM: begin
				if (md_rsp.done) state_d = pac_pkg::ST_EMIT;
			end
			pac_pkg::ST_READ: state_d = pac_pkg::ST_EMIT;
			pac_pkg::ST_EMIT: begin
				if (out_free) state_d = pac_pkg::ST_IDLE;
			end
			default: state_d = pac_pkg::ST_IDLE;
		endcase
	end

	// outputs: handshake, unit start, ring access
	always_comb begin
		req.ready = 1'b0;
		md_req    = '0;
		md_req.b  = rate_q;
		md_req.d  = pac_pkg::MS_PER_S;
		ring_req.we    = 1'b0;
		ring_req.waddr = wp_q;
		ring_req.wdata = req.sample;
		ring_req.re    = 1'b0;
		ring_req.raddr = req.read_address;
		unique case (state_q)
			pac_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					ring_req.we = is_append;
					ring_req.re = is_read;
					if (is_append && !rec_q) begin
						md_req.go = 1'b1;
						md_req.a  = pac_pkg::MD_A_W'(pre_pad_q);
					end else if (is_append && req.chunk_end) begin
						md_req.go = 1'b1;
						md_req.a  = pac_pkg::MD_A_W'(max_dur_q);
					end else if (is_end && rec_q && dur_pos) begin
						md_req.go = 1'b1;
						md_req.a  = dur[TW-1:0];
					end
				end
			end
			pac_pkg::ST_CAP: begin
				if (md_rsp.done && over && rate_nz) begin
					md_req.go = 1'b1;
					md_req.a  = pac_pkg::MD_A_W'(drop);
					md_req.b  = pac_pkg::MS_PER_S;
					md_req.d  = rate_q;
				end
			end
			pac_pkg::ST_PRE, pac_pkg::ST_DROP, pac_pkg::ST_TRIM,
			pac_pkg::ST_READ, pac_pkg::ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pac_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// register writes
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q     <= pac_pkg::RATE_W'(16000);
			pre_pad_q  <= pac_pkg::PAD_W'(300);
			post_pad_q <= pac_pkg::PAD_W'(300);
			max_dur_q  <= pac_pkg::MAXD_W'(30000);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				pac_pkg::REG_RATE:     rate_q     <= cfg.data;
				pac_pkg::REG_PRE_PAD:  pre_pad_q  <= cfg.data[pac_pkg::PAD_W-1:0];
				pac_pkg::REG_POST_PAD: post_pad_q <= cfg.data[pac_pkg::PAD_W-1:0];
				pac_pkg::REG_MAX_DUR:  max_dur_q  <= cfg.data[pac_pkg::MAXD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// capture state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rec_q   <= 1'b0;
			pre_q   <= '0;
			base_q  <= '0;
			len_q   <= '0;
			start_q <= '0;
		end else begin
			case (state_q)
				pac_pkg::ST_IDLE: begin
					if (fire && is_append) begin
						wp_q <= wp_q + 1'b1;
						if (rec_q) begin
							if (len_q < pac_pkg::DEPTH_LEN) len_q <= len_q + 1'b1;
							else base_q <= base_q + 1'b1;
						end
					end else if (fire && is_start) begin
						base_q  <= wp_q - pre_q[AW-1:0];
						len_q   <= pre_q;
						pre_q   <= '0;
						start_q <= req.time_ms;
						rec_q   <= 1'b1;
					end else if (fire && is_abort && rec_q) begin
						rec_q   <= 1'b0;
						base_q  <= '0;
						len_q   <= '0;
						start_q <= '0;
					end else if (fire && is_end && rec_q) begin
						rec_q <= 1'b0;
						if (!dur_pos) len_q <= '0;
					end
				end
				pac_pkg::ST_PRE: begin
					if (md_rsp.done) pre_q <= (pre_inc > q_sat) ? q_sat : pre_inc;
				end
				pac_pkg::ST_CAP: begin
					if (md_rsp.done && over) begin
						base_q <= base_q + drop[AW-1:0];
						len_q  <= cap;
					end
				end
				pac_pkg::ST_DROP: begin
					if (md_rsp.done) start_q <= start_q + md_rsp.q[TW-1:0];
				end
				pac_pkg::ST_TRIM: begin
					if (md_rsp.done) len_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// pending result fields
	always_ff @(posedge clk) begin
		case (state_q)
			pac_pkg::ST_IDLE: begin
				if (fire && is_end) begin
					res_sample_q <= '0;
					if (rec_q) begin
						res_kind_q  <= pac_pkg::KIND_SLICE;
						res_base_q  <= base_q;
						res_len_q   <= len_q;
						res_start_q <= start_q;
						res_end_q   <= req.time_ms;
					end else begin
						res_kind_q  <= pac_pkg::KIND_NO_SLICE;
						res_base_q  <= '0;
						res_len_q   <= '0;
						res_start_q <= '0;
						res_end_q   <= '0;
					end
				end
			end
			pac_pkg::ST_TRIM: begin
				if (md_rsp.done && md_rsp.q != '0 && PW'(len_q) > md_rsp.q) begin
					res_len_q <= md_rsp.q[LW-1:0];
				end
			end
			pac_pkg::ST_READ: begin
				res_kind_q   <= pac_pkg::KIND_READ;
				res_base_q   <= '0;
				res_len_q    <= '0;
				res_start_q  <= '0;
				res_end_q    <= '0;
				res_sample_q <= ring_rdata;
			end
			default: begin
			end
		endcase
	end

	// output register: load from the pending result, drop on a taken beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == pac_pkg::ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pac_pkg::ST_EMIT && out_free) begin
			out_kind_q   <= res_kind_q;
			out_base_q   <= res_base_q;
			out_len_q    <= res_len_q;
			out_start_q  <= res_start_q;
			out_end_q    <= res_end_q;
			out_sample_q <= res_sample_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.result_kind    = out_kind_q;
	assign rsp.slice_base     = out_base_q;
	assign rsp.slice_length   = out_len_q;
	assign rsp.slice_start_ms = out_start_q;
	assign rsp.slice_end_ms   = out_end_q;
	assign rsp.read_sample    = out_sample_q;

	pac_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	pac_ring u_ring (
		.clk   (clk),
		.req   (ring_req),
		.rdata (ring_rdata)
	);

endmodule
`default_nettype wire

// ===== test/pac_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_scoreboard
// Watches the command, result and register channels of the capture core,
// keeps its own copy of ring, pointers and registers, works out the result
// of every accepted command and compares each result beat field by field.
// ----------------------------------------------------------------------------
module pac_scoreboard
	import pac_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	pac_req_if        req,
	pac_rsp_if        rsp,
	pac_cfg_if        cfg,
	output int        fails,
	output int        pending
);

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [ADDR_W-1:0]   base;
		logic [LEN_W-1:0]    length;
		logic [TIME_W-1:0]   start_ms;
		logic [TIME_W-1:0]   end_ms;
		logic [SAMPLE_W-1:0] smp;
	} slice_result_t;

	localparam int EXP_DEPTH = 16;

	// expected results, oldest at exp_head
	slice_result_t exp_mem [0:EXP_DEPTH-1];
	int            exp_head;
	int            exp_tail;
	int            exp_count;

	logic [SAMPLE_W-1:0] ring [0:DEPTH-1];
	logic [ADDR_W-1:0]   wr_ptr;
	logic                recording;
	logic [LEN_W-1:0]    pre_fill;
	logic [ADDR_W-1:0]   act_base;
	logic [LEN_W-1:0]    act_len;
	logic [TIME_W-1:0]   act_start;
	logic [RATE_W-1:0]   rate;
	logic [PAD_W-1:0]    pre_pad;
	logic [PAD_W-1:0]    post_pad;
	logic [MAXD_W-1:0]   max_dur;

	function automatic longint unsigned to_samples(longint unsigned ms);
		return longint'(rate) * ms / 64'd1000;
	endfunction

	function automatic longint unsigned clamp_store(longint unsigned c);
		return (c > STORE_LIMIT) ? longint'(STORE_LIMIT) : c;
	endfunction

	task automatic report(string what, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		fails++;
	endtask

	// queue one expected result
	task automatic add_expected(slice_result_t r);
		if (exp_count == EXP_DEPTH) begin
			report("expectation overflow", exp_count, EXP_DEPTH);
			return;
		end
		exp_mem[exp_tail] = r;
		exp_tail = (exp_tail + 1) % EXP_DEPTH;
		exp_count++;
	endtask

	// append one sample, roll the pre-buffer or grow the slice
	task automatic store_sample(logic [SAMPLE_W-1:0] s, logic chunk_end);
		longint unsigned cap;
		longint unsigned drop;
		ring[wr_ptr] = s;
		wr_ptr = wr_ptr + 1'b1;
		if (!recording) begin
			cap = clamp_store(to_samples(pre_pad));
			pre_fill = (longint'(pre_fill) + 1 > cap) ? LEN_W'(cap) : pre_fill + 1'b1;
			return;
		end
		if (act_len < DEPTH_LEN)
			act_len = act_len + 1'b1;
		else
			act_base = act_base + 1'b1;
		if (chunk_end) begin
			cap = to_samples(max_dur);
			cap = (cap == 0) ? longint'(STORE_LIMIT) : clamp_store(cap);
			if (act_len > cap) begin
				drop = act_len - cap;
				act_base = act_base + ADDR_W'(drop);
				act_len = LEN_W'(cap);
				if (rate != 0)
					act_start = act_start + TIME_W'(drop * 1000 / rate);
			end
		end
	endtask

	// work out the result, if any, of one accepted command
	task automatic predict_command();
		slice_result_t r;
		logic [TIME_W-1:0] d;
		longint signed dur;
		longint unsigned target;
		logic [LEN_W-1:0] len;
		r = '0;
		case (req.command)
			CMD_APPEND: store_sample(req.sample, req.chunk_end);
			CMD_START: begin
				act_base = wr_ptr - ADDR_W'(pre_fill);
				act_len = pre_fill;
				pre_fill = '0;
				act_start = req.time_ms;
				recording = 1'b1;
			end
			CMD_ABORT: begin
				if (recording) begin
					recording = 1'b0;
					act_base = '0;
					act_len = '0;
					act_start = '0;
				end
			end
			CMD_READ: begin
				r.kind = KIND_READ;
				r.smp = ring[req.read_address];
				add_expected(r);
			end
			CMD_END: begin
				if (!recording) begin
					r.kind = KIND_NO_SLICE;
				end else begin
					d = req.time_ms - act_start;
					dur = longint'(signed'(d)) + longint'(post_pad);
					len = act_len;
					if (dur > 0) begin
						target = to_samples(dur);
						if (target > 0 && longint'(len) > target)
							len = LEN_W'(target);
					end
					r.kind = KIND_SLICE;
					r.base = act_base;
					r.length = len;
					r.start_ms = act_start;
					r.end_ms = req.time_ms;
					recording = 1'b0;
					act_len = '0;
				end
				add_expected(r);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		slice_result_t w;
		if (!arst_n) begin
			exp_head = 0;
			exp_tail = 0;
			exp_count = 0;
			wr_ptr = '0;
			recording = 1'b0;
			pre_fill = '0;
			act_base = '0;
			act_len = '0;
			act_start = '0;
			rate = RATE_W'(16000);
			pre_pad = PAD_W'(300);
			post_pad = PAD_W'(300);
			max_dur = MAXD_W'(30000);
			fails = 0;
		end else begin
			// register writes
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_RATE:     rate = cfg.data[RATE_W-1:0];
					REG_PRE_PAD:  pre_pad = cfg.data[PAD_W-1:0];
					REG_POST_PAD: post_pad = cfg.data[PAD_W-1:0];
					REG_MAX_DUR:  max_dur = cfg.data[MAXD_W-1:0];
					default: ;
				endcase
			end
			// compare a result beat with the oldest expectation
			if (rsp.valid && rsp.ready) begin
				if (exp_count == 0) begin
					report("unexpected result", rsp.result_kind, 0);
				end else begin
					w = exp_mem[exp_head];
					exp_head = (exp_head + 1) % EXP_DEPTH;
					exp_count--;
					if (rsp.result_kind !== w.kind)
						report("result_kind", rsp.result_kind, w.kind);
					if (rsp.slice_base !== w.base)
						report("slice_base", rsp.slice_base, w.base);
					if (rsp.slice_length !== w.length)
						report("slice_length", rsp.slice_length, w.length);
					if (rsp.slice_start_ms !== w.start_ms)
						report("slice_start_ms", rsp.slice_start_ms, w.start_ms);
					if (rsp.slice_end_ms !== w.end_ms)
						report("slice_end_ms", rsp.slice_end_ms, w.end_ms);
					if (rsp.read_sample !== w.smp)
						report("read_sample", rsp.read_sample, w.smp);
				end
			end
			if (req.valid && req.ready)
				predict_command();
		end
		pending = exp_count;
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the pre-trigger capture core: directed corner cases, a bulk
// gap-free recording, then random start/append/end sequences with aborts,
// reads and noise under several register settings, with random stalls on both sides in all but one phase.
// ----------------------------------------------------------------------------
module testbench;
	import pac_pkg::*;

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	bit   no_gaps;
	int   appended;

	pac_req_if req ();
	pac_rsp_if rsp ();
	pac_cfg_if cfg ();

	pretrigger_audio_capture_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source),
		.cfg    (cfg.sink)
	);

	pac_scoreboard scoreboard (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.cfg     (cfg),
		.fails   (fails),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop
	initial begin
		#200ms;
		$display("CHECK FAILED");
		$finish;
	end

	// one command beat; valid stays high when no gap follows
	task automatic send(logic [CMD_W-1:0] c, logic [SAMPLE_W-1:0] s, logic ce,
			logic [TIME_W-1:0] t, logic [ADDR_W-1:0] a);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.command <= c;
		req.sample <= s;
		req.chunk_end <= ce;
		req.time_ms <= t;
		req.read_address <= a;
		do @(posedge clk); while (!req.ready);
		if (c == CMD_APPEND)
			appended++;
	endtask

	task automatic read_back();
		int top;
		if (appended == 0)
			return;
		top = (appended >= DEPTH) ? DEPTH - 1 : appended - 1;
		send(CMD_READ, SAMPLE_W'($urandom), 1'($urandom), TIME_W'($urandom),
			ADDR_W'($urandom_range(0, top)));
	endtask

	// drain: wait until every expected result has come, then let the block settle
	task automatic drain();
		req.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= CFG_DATA_W'(value);
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(int unsigned r, int unsigned pre, int unsigned post,
			int unsigned maxd);
		drain();
		write_reg(REG_RATE, r);
		write_reg(REG_PRE_PAD, pre);
		write_reg(REG_POST_PAD, post);
		write_reg(REG_MAX_DUR, maxd);
	endtask

	// result side stalls
	initial begin
		int hold;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = no_gaps ? 0 : $urandom_range(0, 16);
			if (hold > 0) begin
				rsp.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	initial begin
		logic [TIME_W-1:0] t0;
		int items;
		int n;
		req.valid = 1'b0;
		req.command = CMD_APPEND;
		req.sample = '0;
		req.chunk_end = 1'b0;
		req.time_ms = '0;
		req.read_address = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_RATE;
		cfg.data = '0;
		no_gaps = 1'b0;
		appended = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle corner cases under reset values
		send(CMD_END, 0, 0, 32'hFFFF_FFFF, 0);
		send(CMD_ABORT, 0, 0, 0, 0);
		send(3'd5, 16'hFFFF, 1, 32'hFFFF_FFFF, '1);
		send(3'd6, 0, 0, 0, 0);
		send(3'd7, 0, 0, 0, 0);
		send(CMD_APPEND, 16'h8000, 0, 0, 0);
		send(CMD_APPEND, 16'h7FFF, 1, 0, 0);
		send(CMD_APPEND, 16'hFFFF, 0, 0, 0);
		send(CMD_READ, 0, 0, 0, 0);
		send(CMD_READ, 0, 0, 0, 1);
		send(CMD_START, 0, 0, 32'd1000, 0);
		send(CMD_START, 0, 0, 32'd2000, 0);
		send(CMD_APPEND, 16'h1234, 0, 0, 0);
		send(CMD_END, 0, 0, 32'd1000, 0);
		send(CMD_START, 0, 0, 32'd5, 0);
		send(CMD_APPEND, 16'h0001, 1, 0, 0);
		send(CMD_END, 0, 0, 32'h8000_0005, 0);
		send(CMD_START, 0, 0, 32'hFFFF_FFF0, 0);
		send(CMD_ABORT, 0, 0, 0, 0);

		// directed: short cap with head drop, zero rate, extremes
		set_regs(1000, 2, 0, 1);
		for (int i = 0; i < 4; i++)
			send(CMD_APPEND, SAMPLE_W'(i), 0, 0, 0);
		send(CMD_START, 0, 0, 32'd100, 0);
		for (int i = 0; i < 5; i++)
			send(CMD_APPEND, 16'h4000 + SAMPLE_W'(i), i == 4, 0, 0);
		send(CMD_END, 0, 0, 32'd101, 0);
		set_regs(0, 0, 0, 0);
		send(CMD_START, 0, 0, 32'd7, 0);
		send(CMD_APPEND, 16'h5555, 1, 0, 0);
		send(CMD_END, 0, 0, 32'd9, 0);
		set_regs(192000, 2000, 2000, 60000);
		send(CMD_APPEND, 16'hAAAA, 1, 0, 0);
		send(CMD_START, 0, 0, 32'd0, 0);
		send(CMD_APPEND, 16'h7FFF, 1, 0, 0);
		send(CMD_END, 0, 0, 32'h7FFF_FFFF, 0);

		// bulk: one long gap-free recording whose last append closes a chunk
		set_regs(16000, 0, 2000, 0);
		no_gaps = 1'b1;
		send(CMD_START, 0, 0, 32'd42, 0);
		for (int i = 0; i < 200; i++)
			send(CMD_APPEND, SAMPLE_W'($urandom), 0, 0, 0);
		send(CMD_APPEND, SAMPLE_W'($urandom), 1, 0, 0);
		send(CMD_END, 0, 0, 32'hFFFF_0000, 0);
		no_gaps = 1'b0;
		drain();

		// random phases, each under its own register setting
		items = 0;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_regs(16000, 5, 3, 10);
				1: set_regs(192000, 0, 0, 1);
				2: set_regs(0, 2000, 2000, 60000);
				3: set_regs($urandom_range(1, 192000), $urandom_range(0, 3),
					$urandom_range(0, 2000), $urandom_range(0, 3));
				4: set_regs(1000, 20, 10, 0);
				default: set_regs($urandom_range(500, 8000), $urandom_range(0, 20),
					$urandom_range(0, 50), $urandom_range(1, 20));
			endcase
			no_gaps = (ph == 4);
			while (items < (ph + 1) * 300) begin
				if ($urandom_range(0, 3) != 0) begin
					// well-formed recording with random content
					n = $urandom_range(0, 12);
					for (int i = 0; i < n; i++)
						send(CMD_APPEND, SAMPLE_W'($urandom), $urandom_range(0, 3) == 0, 0, 0);
					t0 = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 100000);
					send(CMD_START, 0, 0, t0, 0);
					n = $urandom_range(0, 40);
					for (int i = 0; i < n; i++)
						send(CMD_APPEND, SAMPLE_W'($urandom), $urandom_range(0, 4) == 0, 0, 0);
					if ($urandom_range(0, 9) == 0)
						send(CMD_ABORT, 0, 0, 0, 0);
					send(CMD_END, 0, 0, ($urandom_range(0, 7) == 0) ? $urandom :
						t0 + $urandom_range(0, 40) - 10, 0);
					read_back();
					items += n + 4;
				end else begin
					// noise
					n = $urandom_range(0, 7);
					if (n == CMD_READ)
						read_back();
					else
						send(CMD_W'(n), SAMPLE_W'($urandom), 1'($urandom), $urandom,
							ADDR_W'($urandom));
					items++;
				end
				// hold off until every result has come, near each multiple of 300 items
				if (items % 300 < 8 && pending != 0) begin
					req.valid <= 1'b0;
					do @(negedge clk); while (pending != 0);
					@(posedge clk);
				end
			end
		end

		no_gaps = 1'b0;
		req.valid <= 1'b0;
		fork
			begin
				do @(negedge clk); while (pending != 0);
				repeat (150) @(posedge clk);
			end
			begin
				repeat (200000) @(posedge clk);
			end
		join_any
		if (fails == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
